// ----- src/hbmsr_pkg.sv -----
package hbmsr_pkg;

  localparam int SPEED_W = 16;
  localparam int DUR_W = 32;
  localparam int DUTY_W = 16;
  localparam int PERIOD_W = 16;
  localparam int BAND_W = 15;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam int RAMP_STEPS_DEF = 50;

  localparam logic [DUTY_W-1:0] FULL_SCALE_RST = 16'd8191;
  localparam logic [PERIOD_W-1:0] STEP_PERIOD_RST = 16'd20;
  localparam logic [BAND_W-1:0] ZERO_BAND_RST = 15'd328;

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_START = 2'd1,
    CMD_TIMED = 2'd2,
    CMD_STOP = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FULL_SCALE = 2'd0,
    CFG_STEP_PERIOD = 2'd1,
    CFG_ZERO_BAND = 2'd2
  } cfg_idx_e;

  // State snapshot after the latest update, plus what the duty stage must do.
  typedef struct packed {
    logic dir_a;
    logic dir_b;
    logic standby;
    logic ramping;
    logic signed [SPEED_W-1:0] present_speed;
    logic step;
    logic clear;
  } ramp_stat_t;

  // Magnitude of a Q1.15 speed; -1.0 gives 32768.
  function automatic logic [SPEED_W:0] speed_mag(input logic signed [SPEED_W-1:0] v);
    logic signed [SPEED_W:0] w;
    w = {v[SPEED_W-1], v};
    return w[SPEED_W] ? (SPEED_W + 1)'(-w) : (SPEED_W + 1)'(w);
  endfunction

  // Clamp an 18-bit sum into the signed 16-bit range.
  function automatic logic signed [SPEED_W-1:0] sat_speed(input logic signed [SPEED_W+1:0] v);
    logic signed [SPEED_W+1:0] hi;
    logic signed [SPEED_W+1:0] lo;
    hi = 18'sd32767;
    lo = -18'sd32768;
    if (v > hi) begin
      return 16'sh7fff;
    end else if (v < lo) begin
      return 16'sh8000;
    end
    return v[SPEED_W-1:0];
  endfunction

endpackage

// ----- src/hbmsr_if.sv -----
interface hbmsr_cmd_if;
  import hbmsr_pkg::*;
  logic valid;
  logic ready;
  logic [1:0] cmd;
  logic signed [SPEED_W-1:0] speed;
  logic [DUR_W-1:0] duration;

  modport source (output valid, output cmd, output speed, output duration, input ready);
  modport sink (input valid, input cmd, input speed, input duration, output ready);
endinterface

interface hbmsr_res_if;
  import hbmsr_pkg::*;
  logic valid;
  logic ready;
  logic dir_a;
  logic dir_b;
  logic standby;
  logic [DUTY_W-1:0] duty;
  logic ramping;
  logic signed [SPEED_W-1:0] present_speed;

  modport source (output valid, output dir_a, output dir_b, output standby, output duty,
                  output ramping, output present_speed, input ready);
  modport sink (input valid, input dir_a, input dir_b, input standby, input duty,
                input ramping, input present_speed, output ready);
endinterface

// ----- src/hbmsr_ramp_ctrl.sv -----
module hbmsr_ramp_ctrl
  import hbmsr_pkg::*;
#(
  parameter int RAMP_STEPS = RAMP_STEPS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic adv,
  input  logic [1:0] cmd,
  input  logic signed [SPEED_W-1:0] speed,
  input  logic [DUR_W-1:0] duration,
  input  logic [PERIOD_W-1:0] step_period,
  input  logic [BAND_W-1:0] zero_band,
  output ramp_stat_t stat
);

  localparam int IDX_W = $clog2(RAMP_STEPS + 1);
  localparam int RECIP_SHIFT = 22;
  localparam int RECIP_W = RECIP_SHIFT + 1;
  // ceil(2^22 / steps): exact floor division for any 16-bit magnitude
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((1 << RECIP_SHIFT) + RAMP_STEPS - 1) / RAMP_STEPS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RAMP_STEPS);

  logic signed [SPEED_W-1:0] speed_now, speed_now_next;
  logic signed [SPEED_W-1:0] target_speed, target_speed_next;
  logic signed [SPEED_W:0] ramp_increment, ramp_increment_next;
  logic [IDX_W-1:0] step_index, step_index_next;
  logic [PERIOD_W-1:0] period_count, period_count_next;
  logic pending_change, pending_change_next;
  logic in_ramp, in_ramp_next;
  logic standby_flag, standby_flag_next;
  logic [1:0] dir_bits, dir_bits_next;
  logic [DUR_W-1:0] stop_countdown, stop_countdown_next;
  logic timer_armed, timer_armed_next;
  logic step_flag, step_flag_next;
  logic clear_flag, clear_flag_next;

  logic expire;
  logic signed [SPEED_W-1:0] tick_target;
  logic signed [SPEED_W:0] diff;
  logic [SPEED_W-1:0] diff_mag;
  logic [SPEED_W+RECIP_W-1:0] quot_prod;
  logic signed [SPEED_W:0] quot_s;
  logic signed [SPEED_W:0] incr_new;
  logic signed [SPEED_W:0] inc_sel;
  logic signed [SPEED_W+1:0] step_sum;
  logic signed [SPEED_W-1:0] step_speed;
  logic [PERIOD_W-1:0] per_eff;
  logic [PERIOD_W-1:0] pc_inc;

  // Increment for a ramp that starts on this tick: (target - now) / steps,
  // truncated toward zero.
  assign expire = timer_armed && (stop_countdown == DUR_W'(1));
  assign tick_target = expire ? '0 : target_speed;
  assign diff = (SPEED_W + 1)'(tick_target) - (SPEED_W + 1)'(speed_now);
  assign diff_mag = diff[SPEED_W] ? SPEED_W'(-diff) : SPEED_W'(diff);
  assign quot_prod = diff_mag * RECIP;
  assign quot_s = {1'b0, quot_prod[RECIP_SHIFT +: SPEED_W]};
  assign incr_new = diff[SPEED_W] ? -quot_s : quot_s;

  assign inc_sel = in_ramp ? ramp_increment : incr_new;
  assign step_sum = (SPEED_W + 2)'(speed_now) + (SPEED_W + 2)'(inc_sel);
  assign step_speed = sat_speed(step_sum);

  assign per_eff = (step_period == '0) ? PERIOD_W'(1) : step_period;
  assign pc_inc = period_count + PERIOD_W'(1);

  always_comb begin
    speed_now_next = speed_now;
    target_speed_next = target_speed;
    ramp_increment_next = ramp_increment;
    step_index_next = step_index;
    period_count_next = period_count;
    pending_change_next = pending_change;
    in_ramp_next = in_ramp;
    standby_flag_next = standby_flag;
    dir_bits_next = dir_bits;
    stop_countdown_next = stop_countdown;
    timer_armed_next = timer_armed;
    step_flag_next = 1'b0;
    clear_flag_next = 1'b0;

    case (cmd_e'(cmd))
      CMD_START: begin
        target_speed_next = speed;
        pending_change_next = 1'b1;
      end
      CMD_TIMED: begin
        if (duration != '0) begin
          target_speed_next = speed;
          pending_change_next = 1'b1;
          stop_countdown_next = duration;
          timer_armed_next = 1'b1;
        end
      end
      CMD_STOP: begin
        target_speed_next = '0;
        pending_change_next = 1'b1;
      end
      CMD_TICK: begin
        if (timer_armed) begin
          stop_countdown_next = stop_countdown - DUR_W'(1);
          if (expire) begin
            timer_armed_next = 1'b0;
            target_speed_next = '0;
            pending_change_next = 1'b1;
          end
        end
        if (in_ramp) begin
          period_count_next = pc_inc;
          if (pc_inc >= per_eff) begin
            period_count_next = '0;
            if (step_index < LAST_IDX) begin
              speed_now_next = step_speed;
              dir_bits_next = (step_speed > 0) ? 2'b01 : 2'b10;
              standby_flag_next = 1'b0;
              step_index_next = step_index + IDX_W'(1);
              step_flag_next = 1'b1;
            end else begin
              in_ramp_next = 1'b0;
              if (speed_mag(speed_now) < {2'b00, zero_band}) begin
                dir_bits_next = 2'b00;
                standby_flag_next = 1'b1;
                clear_flag_next = 1'b1;
              end
            end
          end
        end else if (pending_change_next) begin
          pending_change_next = 1'b0;
          in_ramp_next = 1'b1;
          period_count_next = '0;
          ramp_increment_next = incr_new;
          speed_now_next = step_speed;
          dir_bits_next = (step_speed > 0) ? 2'b01 : 2'b10;
          standby_flag_next = 1'b0;
          step_index_next = IDX_W'(1);
          step_flag_next = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_now <= '0;
      target_speed <= '0;
      ramp_increment <= '0;
      step_index <= '0;
      period_count <= '0;
      pending_change <= 1'b0;
      in_ramp <= 1'b0;
      standby_flag <= 1'b1;
      dir_bits <= 2'b00;
      stop_countdown <= '0;
      timer_armed <= 1'b0;
      step_flag <= 1'b0;
      clear_flag <= 1'b0;
    end else if (adv) begin
      speed_now <= speed_now_next;
      target_speed <= target_speed_next;
      ramp_increment <= ramp_increment_next;
      step_index <= step_index_next;
      period_count <= period_count_next;
      pending_change <= pending_change_next;
      in_ramp <= in_ramp_next;
      standby_flag <= standby_flag_next;
      dir_bits <= dir_bits_next;
      stop_countdown <= stop_countdown_next;
      timer_armed <= timer_armed_next;
      step_flag <= step_flag_next;
      clear_flag <= clear_flag_next;
    end
  end

  assign stat.dir_a = dir_bits[0];
  assign stat.dir_b = dir_bits[1];
  assign stat.standby = standby_flag;
  assign stat.ramping = in_ramp;
  assign stat.present_speed = speed_now;
  assign stat.step = step_flag;
  assign stat.clear = clear_flag;

`ifndef SYNTHESIS
  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    step_index <= LAST_IDX)
    else $error("step index beyond ramp length");

  a_ramp_starts_at_one: assert property (@(posedge clk) disable iff (rst)
    $rose(in_ramp) |-> step_index == IDX_W'(1))
    else $error("ramp entered without its first step");

  a_idle_period_clear: assert property (@(posedge clk) disable iff (rst)
    !in_ramp |-> period_count == '0)
    else $error("period counter running outside a ramp");
`endif

endmodule

// ----- src/hbridge_motor_speed_ramp_unit.sv -----
// H-bridge speed ramp. Each input word is a command (tick, start, timed start,
// stop) and every accepted word yields exactly one result word showing the
// bridge pins, standby, PWM duty, ramp status and present Q1.15 speed after
// that word is applied. A start latches a target; the next tick while idle
// begins a linear ramp of RAMP_STEPS steps, one step every step_period ticks,
// and the ramp ends one period after its last step, dropping into standby if
// the final speed is inside the zero band. A timed start with a nonzero
// duration also arms a one-shot timer that forces the target to zero when it
// runs out. Throughput is one word per clock while the result side does not
// stall; each word passes from the input register through the state update
// (including the multiply-by-reciprocal that forms the step size) and then
// the duty multiplier into the result register. Stalls on the result side
// back up through the pipeline without losing words. Write configuration
// only while the unit is idle with all results taken.
module hbridge_motor_speed_ramp_unit
  import hbmsr_pkg::*;
#(
  parameter int RAMP_STEPS = RAMP_STEPS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  hbmsr_cmd_if.sink item,
  hbmsr_res_if.source result
);

  // configuration registers
  logic [DUTY_W-1:0] full_scale_duty;
  logic [PERIOD_W-1:0] step_period;
  logic [BAND_W-1:0] zero_band;

  // input register stage
  logic a_valid;
  logic [1:0] a_cmd;
  logic signed [SPEED_W-1:0] a_speed;
  logic [DUR_W-1:0] a_duration;

  // update stage: the state registers in the controller hold its payload
  logic b_valid;
  ramp_stat_t stat;

  // result register stage
  logic c_valid;
  logic c_dir_a;
  logic c_dir_b;
  logic c_standby;
  logic c_ramping;
  logic signed [SPEED_W-1:0] c_speed;
  logic [DUTY_W-1:0] duty_reg;

  logic c_ready, b_ready, b_adv, a_adv, in_take;
  logic [SPEED_W:0] duty_mag;
  logic [SPEED_W+DUTY_W:0] duty_prod;

  assign c_ready = !c_valid || result.ready;
  assign b_adv = b_valid && c_ready;
  assign b_ready = !b_valid || c_ready;
  assign a_adv = a_valid && b_ready;
  assign item.ready = !a_valid || b_ready;
  assign in_take = item.valid && item.ready;

  // Hold config; writes to an unused index are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      full_scale_duty <= FULL_SCALE_RST;
      step_period <= STEP_PERIOD_RST;
      zero_band <= ZERO_BAND_RST;
    end else if (cfg_we) begin
      case (cfg_idx_e'(cfg_idx))
        CFG_FULL_SCALE: full_scale_duty <= cfg_data[DUTY_W-1:0];
        CFG_STEP_PERIOD: step_period <= cfg_data[PERIOD_W-1:0];
        CFG_ZERO_BAND: zero_band <= cfg_data[BAND_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Capture the incoming word whenever the stage is free or draining.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (item.ready) begin
      a_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      a_cmd <= item.cmd;
      a_speed <= item.speed;
      a_duration <= item.duration;
    end
  end

  // Advance the controller state one word at a time.
  hbmsr_ramp_ctrl #(
    .RAMP_STEPS(RAMP_STEPS)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .adv(a_adv),
    .cmd(a_cmd),
    .speed(a_speed),
    .duration(a_duration),
    .step_period(step_period),
    .zero_band(zero_band),
    .stat(stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_ready) begin
      b_valid <= a_valid;
    end
  end

  // Duty follows the magnitude of the stepped speed; -1.0 counts as full
  // magnitude. Keep the low 16 bits of (|speed| * full_scale) >> 15.
  assign duty_mag = speed_mag(stat.present_speed);
  assign duty_prod = duty_mag * full_scale_duty;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
      duty_reg <= '0;
    end else begin
      if (c_ready) begin
        c_valid <= b_valid;
      end
      if (b_adv) begin
        if (stat.step) begin
          duty_reg <= duty_prod[15 +: DUTY_W];
        end else if (stat.clear) begin
          duty_reg <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv) begin
      c_dir_a <= stat.dir_a;
      c_dir_b <= stat.dir_b;
      c_standby <= stat.standby;
      c_ramping <= stat.ramping;
      c_speed <= stat.present_speed;
    end
  end

  assign result.valid = c_valid;
  assign result.dir_a = c_dir_a;
  assign result.dir_b = c_dir_b;
  assign result.standby = c_standby;
  assign result.duty = duty_reg;
  assign result.ramping = c_ramping;
  assign result.present_speed = c_speed;

`ifndef SYNTHESIS
  a_standby_no_duty: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.standby |-> result.duty == '0)
    else $error("duty driven while in standby");

  a_standby_pins_low: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.standby |-> !result.dir_a && !result.dir_b)
    else $error("bridge pins active in standby");

  a_one_dir_active: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.standby |-> result.dir_a != result.dir_b)
    else $error("bridge direction pins not exclusive");
`endif

endmodule
